[hw/rtl/rss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_pkg
// Shared widths, types and state encoding for the running sample statistics
// unit.
// ----------------------------------------------------------------------------
package rss_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int FRAC_BITS   = 16;
	localparam int MAX_COUNT   = 1024;
	localparam int CNT_W       = $clog2(MAX_COUNT + 1);
	// exact sum of MAX_COUNT full-scale samples
	localparam int SUM_W       = SAMPLE_W + CNT_W - 1;
	localparam int SQ_W        = 2 * SAMPLE_W + CNT_W - 2;
	localparam int SQ_LO_W     = SQ_W / 2;
	localparam int SQ_HI_W     = SQ_W - SQ_LO_W;
	localparam int MAGSQ_W     = 2 * SUM_W;
	localparam int NUM_W       = SQ_W + CNT_W;
	localparam int DEN_W       = 2 * CNT_W;
	localparam int DIV_W       = NUM_W + FRAC_BITS;
	localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
	localparam int MEAN_W      = 32;
	localparam int VAR_W       = 47;
	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

	// totals of one finished set
	typedef struct packed {
		logic [CNT_W-1:0]           count;
		logic signed [SAMPLE_W-1:0] maximum;
		logic signed [SAMPLE_W-1:0] minimum;
		logic signed [SUM_W-1:0]    sum;
		logic [SQ_W-1:0]            sqsum;
		logic                       drop;
	} rss_set_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} rss_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} rss_div_rsp_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_ABS,
		BK_MUL,
		BK_ADD,
		BK_SUB,
		BK_MEAN_GO,
		BK_MEAN_WAIT,
		BK_VAR_GO,
		BK_VAR_WAIT,
		BK_OUT
	} rss_back_state_t;

endpackage
`default_nettype wire

[hw/rtl/rss_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_in_if
// Sample channel: one signed sample and its last-of-set flag per beat.
// ----------------------------------------------------------------------------
interface rss_in_if
	import rss_pkg::*;
();

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);

endinterface
`default_nettype wire

[hw/rtl/rss_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_out_if
// Result channel: statistics of one finished set per beat.
// ----------------------------------------------------------------------------
interface rss_out_if
	import rss_pkg::*;
();

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] maximum;
	logic signed [SAMPLE_W-1:0] minimum;
	logic signed [MEAN_W-1:0]   mean_q16;
	logic [VAR_W-1:0]           variance_q16;
	logic [CNT_W-1:0]           sample_count;
	logic                       overflowed;

	modport source (
		output valid, output maximum, output minimum, output mean_q16,
		output variance_q16, output sample_count, output overflowed, input ready
	);
	modport sink (
		input valid, input maximum, input minimum, input mean_q16,
		input variance_q16, input sample_count, input overflowed, output ready
	);

endinterface
`default_nettype wire

[hw/rtl/rss_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_front
// Accumulates count, extremes, sum and sum of squares one sample per cycle
// while the queue has room; hands a finished set's totals to the queue.
// ----------------------------------------------------------------------------
module rss_front
	import rss_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	rss_in_if.sink    samples,
	output rss_set_t  push_set,
	output logic      push,
	input  wire logic push_ready
);

	logic [CNT_W-1:0]             cnt_q;
	logic signed [SAMPLE_W-1:0]   max_q;
	logic signed [SAMPLE_W-1:0]   min_q;
	logic signed [SUM_W-1:0]      sum_q;
	logic [SQ_W-1:0]              sq_q;
	logic                         drop_q;

	logic                         beat;
	logic                         take;
	logic signed [2*SAMPLE_W-1:0] square;
	rss_set_t                     nxt;

	assign samples.ready = push_ready;
	assign beat          = samples.valid && samples.ready;
	assign take          = cnt_q < CNT_W'(MAX_COUNT);
	assign square        = samples.sample * samples.sample;

	always_comb begin
		nxt.count   = cnt_q;
		nxt.maximum = max_q;
		nxt.minimum = min_q;
		nxt.sum     = sum_q;
		nxt.sqsum   = sq_q;
		nxt.drop    = drop_q;
		if (take) begin
			nxt.count = cnt_q + 1'b1;
			if (samples.sample > max_q) begin
				nxt.maximum = samples.sample;
			end
			if (samples.sample < min_q) begin
				nxt.minimum = samples.sample;
			end
			nxt.sum   = sum_q + SUM_W'(samples.sample);
			nxt.sqsum = sq_q + SQ_W'($unsigned(square));
		end else begin
			// set too long: sample dropped
			nxt.drop = 1'b1;
		end
	end

	assign push     = beat && samples.last;
	assign push_set = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			max_q  <= SAMPLE_MIN;
			min_q  <= SAMPLE_MAX;
			sum_q  <= '0;
			sq_q   <= '0;
			drop_q <= 1'b0;
		end else if (beat) begin
			if (samples.last) begin
				cnt_q  <= '0;
				max_q  <= SAMPLE_MIN;
				min_q  <= SAMPLE_MAX;
				sum_q  <= '0;
				sq_q   <= '0;
				drop_q <= 1'b0;
			end else begin
				cnt_q  <= nxt.count;
				max_q  <= nxt.maximum;
				min_q  <= nxt.minimum;
				sum_q  <= nxt.sum;
				sq_q   <= nxt.sqsum;
				drop_q <= nxt.drop;
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/rss_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_queue
// Short queue of finished set totals between the front and the back.
// ----------------------------------------------------------------------------
module rss_queue
	import rss_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire rss_set_t push_set,
	output logic          push_ready,
	output logic          head_valid,
	output rss_set_t      head,
	input  wire logic     pop
);

	rss_set_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	assign push_ready = level_q != LVL_W'(QUEUE_DEPTH);
	assign head_valid = level_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/rss_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_divider
// Restoring divider, one quotient bit per cycle, shared by mean and
// variance.
// ----------------------------------------------------------------------------
module rss_divider
	import rss_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire rss_div_req_t req,
	output rss_div_rsp_t      rsp
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] steps_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     div_q;
	logic [DIV_W-1:0]     quo_q;

	logic [DEN_W:0]       shifted;
	logic [DEN_W:0]       diff;
	logic                 ge;

	// dividend shifts out at the top while quotient bits enter at the bottom
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign ge      = shifted >= {1'b0, div_q};

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q   <= 1'b1;
				steps_q <= DIV_CNT_W'(DIV_W);
			end else if (run_q) begin
				steps_q <= steps_q - 1'b1;
				if (steps_q == DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/rss_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_back
// Sequencer that turns set totals into mean and variance and holds the
// result until it is taken.
// ----------------------------------------------------------------------------
module rss_back
	import rss_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         head_valid,
	input  wire rss_set_t     head,
	output logic              pop,
	output rss_div_req_t      div_req,
	input  wire rss_div_rsp_t div_rsp,
	rss_out_if.source         results
);

	localparam int PLO_W = CNT_W + SQ_LO_W;
	localparam int PHI_W = CNT_W + SQ_HI_W;

	rss_back_state_t state_q;
	rss_back_state_t state_nxt;

	rss_set_t            set_q;
	logic [SUM_W-1:0]    mag_q;
	logic                neg_q;
	logic [MAGSQ_W-1:0]  magsq_q;
	logic [DEN_W-1:0]    den_q;
	logic [PLO_W-1:0]    plo_q;
	logic [PHI_W-1:0]    phi_q;
	logic [NUM_W-1:0]    nsq_q;
	logic [NUM_W-1:0]    num_q;
	logic [MEAN_W-1:0]   mean_q;
	logic [VAR_W-1:0]    var_q;

	logic                res_valid_q;
	logic signed [SAMPLE_W-1:0] res_max_q;
	logic signed [SAMPLE_W-1:0] res_min_q;
	logic [MEAN_W-1:0]   res_mean_q;
	logic [VAR_W-1:0]    res_var_q;
	logic [CNT_W-1:0]    res_cnt_q;
	logic                res_ovf_q;

	logic                out_free;
	logic                load_res;

	assign out_free = !res_valid_q || results.ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: begin
				if (head_valid) begin
					state_nxt = BK_ABS;
				end
			end
			BK_ABS:     state_nxt = BK_MUL;
			BK_MUL:     state_nxt = BK_ADD;
			BK_ADD:     state_nxt = BK_SUB;
			BK_SUB:     state_nxt = BK_MEAN_GO;
			BK_MEAN_GO: state_nxt = BK_MEAN_WAIT;
			BK_MEAN_WAIT: begin
				if (div_rsp.done) begin
					state_nxt = BK_VAR_GO;
				end
			end
			BK_VAR_GO:  state_nxt = BK_VAR_WAIT;
			BK_VAR_WAIT: begin
				if (div_rsp.done) begin
					state_nxt = BK_OUT;
				end
			end
			BK_OUT: begin
				if (out_free) begin
					state_nxt = BK_IDLE;
				end
			end
			default:    state_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		pop              = 1'b0;
		load_res         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = DIV_W'(mag_q) << FRAC_BITS;
		div_req.divisor  = DEN_W'(set_q.count);
		case (state_q)
			BK_IDLE:    pop = head_valid;
			BK_MEAN_GO: div_req.start = 1'b1;
			BK_VAR_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(num_q) << FRAC_BITS;
				div_req.divisor  = den_q;
			end
			BK_OUT:     load_res = out_free;
			default:    pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (pop) begin
					set_q <= head;
				end
			end
			BK_ABS: begin
				// the most negative sum wraps to its own magnitude as unsigned
				mag_q <= set_q.sum[SUM_W-1] ? SUM_W'(-set_q.sum) : SUM_W'(set_q.sum);
				neg_q <= set_q.sum[SUM_W-1];
			end
			BK_MUL: begin
				magsq_q <= MAGSQ_W'(mag_q) * MAGSQ_W'(mag_q);
				den_q   <= DEN_W'(set_q.count) * DEN_W'(set_q.count);
				plo_q   <= PLO_W'(set_q.count) * PLO_W'(set_q.sqsum[SQ_LO_W-1:0]);
				phi_q   <= PHI_W'(set_q.count) * PHI_W'(set_q.sqsum[SQ_W-1:SQ_LO_W]);
			end
			BK_ADD: begin
				nsq_q <= (NUM_W'(phi_q) << SQ_LO_W) + NUM_W'(plo_q);
			end
			BK_SUB: begin
				num_q <= nsq_q - NUM_W'(magsq_q);
			end
			BK_MEAN_WAIT: begin
				if (div_rsp.done) begin
					mean_q <= neg_q ? -div_rsp.quotient[MEAN_W-1:0]
						: div_rsp.quotient[MEAN_W-1:0];
				end
			end
			BK_VAR_WAIT: begin
				if (div_rsp.done) begin
					var_q <= div_rsp.quotient[VAR_W-1:0];
				end
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_max_q  <= set_q.maximum;
			res_min_q  <= set_q.minimum;
			res_mean_q <= mean_q;
			res_var_q  <= var_q;
			res_cnt_q  <= set_q.count;
			res_ovf_q  <= set_q.drop;
		end
	end

	assign results.valid        = res_valid_q;
	assign results.maximum      = res_max_q;
	assign results.minimum      = res_min_q;
	assign results.mean_q16     = res_mean_q;
	assign results.variance_q16 = res_var_q;
	assign results.sample_count = res_cnt_q;
	assign results.overflowed   = res_ovf_q;

`ifndef SYNTH
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == BK_MEAN_WAIT || state_q == BK_VAR_WAIT))
		else $error("divider finished outside a wait state");

	a_var_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_VAR_WAIT && div_rsp.done) |->
			div_rsp.quotient[DIV_W-1:VAR_W] == '0)
		else $error("variance quotient wider than result field");

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == BK_ABS)
		else $error("set popped without starting the sequence");

	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |=> state_q == BK_IDLE && res_valid_q)
		else $error("result load did not end the sequence");
`endif

endmodule
`default_nettype wire

[hw/rtl/running_sample_statistics_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// running_sample_statistics_unit
// Count, maximum, minimum, mean and population variance of sample sets.
//
//   channel   dir   payload
//   samples   in    sample (s16), last
//   results   out   maximum, minimum (s16), mean_q16 (s32),
//                   variance_q16 (u47), sample_count (u11), overflowed
//
// samples are taken one per cycle; a beat with last closes the set
// the back part handles one set at a time and runs the one-bit-per-cycle
// divider once for mean, once for variance
// two finished sets queue between front and back; samples stall whenever
// the queue is full
// reset clears all accumulators and leaves the result channel empty
// ----------------------------------------------------------------------------
module running_sample_statistics_unit
	import rss_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	rss_in_if.sink    samples,
	rss_out_if.source results
);

	rss_set_t     push_set;
	logic         push;
	logic         push_ready;
	logic         head_valid;
	rss_set_t     head;
	logic         pop;
	rss_div_req_t div_req;
	rss_div_rsp_t div_rsp;

	rss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.push_set   (push_set),
		.push       (push),
		.push_ready (push_ready)
	);

	rss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_set   (push_set),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	rss_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.results    (results)
	);

endmodule
`default_nettype wire
